>>> hw/rtl/ppc_pkg.sv
// Shared constants and controller/datapath interface types for the parity and prime classifier.
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

  // Width of the value field on both stream ports.
  localparam int unsigned ValueW = 16;

  // Default number of value bits that take part in the classification.
  localparam int unsigned DefaultValueBits = 16;

  // Quotient bits the remainder unit resolves in one cycle.
  localparam int unsigned DivStepBits = 4;

  // Bit positions of the flags in the master-side tuser.
  localparam int unsigned UserEvenBit  = 0;
  localparam int unsigned UserPrimeBit = 1;
  localparam int unsigned UserW        = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;            // capture a new input word, restart the divisor at two
    logic div_start;       // clear the remainder and load the dividend shifter
    logic div_step;        // resolve the next group of dividend bits
    logic next_divisor;    // advance the divisor and its square
    logic mark_prime;      // no divisor found: prime if the value is at least two
    logic mark_composite;  // a divisor was found
    logic out_load;        // move the finished result into the output register
  } ppc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic square_above;    // divisor squared exceeds the value
    logic last_chunk;      // the current step resolves the last dividend bits
    logic rem_zero_next;   // the remainder after the current step is zero
  } ppc_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/parity_prime_classifier.sv
// Top level of the parity and prime classifier: controller plus datapath.
//
//  Channel   | Direction | Payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata: value[15:0]; tlast: last_in_list
//  m_axis    | out       | tdata: value_out[15:0]; tuser: is_even, is_prime;
//            |           | tlast: last_out
//
// One word is worked on at a time. Divisors are tried from two upward, up to
// floor(sqrt(value)), until one divides the word; the shared remainder unit
// resolves each trial four dividend bits at a time. A finished word waits while
// the output register still holds an untaken result. The output register lets
// the next word be taken while a result still waits. Reset is asynchronous and
// clears only the control state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module parity_prime_classifier
  import ppc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DefaultValueBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire [ValueW-1:0]   s_axis_tdata,   // [15:0] value
  input  wire                s_axis_tlast,
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  output logic [ValueW-1:0]  m_axis_tdata,   // [15:0] value_out
  output logic [UserW-1:0]   m_axis_tuser,   // [0] is_even, [1] is_prime
  output logic               m_axis_tlast
);

  ppc_cmd_t    cmd;
  ppc_status_t status;
  logic        out_even;
  logic        out_prime;

  ppc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ppc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_value_o (m_axis_tdata),
    .out_even_o  (out_even),
    .out_prime_o (out_prime),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the flags into tuser.
  always_comb begin
    m_axis_tuser               = '0;
    m_axis_tuser[UserEvenBit]  = out_even;
    m_axis_tuser[UserPrimeBit] = out_prime;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppc_datapath.sv
// Datapath: value registers, divisor and square tracking, remainder unit and output register.
`timescale 1ns / 1ps
`default_nettype none

module ppc_datapath
  import ppc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DefaultValueBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ppc_cmd_t           cmd_i,
  output ppc_status_t        status_o,
  input  wire [ValueW-1:0]   in_value_i,
  input  wire                in_last_i,
  output logic [ValueW-1:0]  out_value_o,
  output logic               out_even_o,
  output logic               out_prime_o,
  output logic               out_last_o
);

  // Classified width, the divisor range it needs and the padded dividend.
  localparam int unsigned VW   = (VALUE_BITS < ValueW) ? VALUE_BITS : ValueW;
  localparam int unsigned HalfW = (VW + 1) / 2;
  localparam int unsigned DW   = HalfW + 1;
  localparam int unsigned SW   = 2 * DW;
  localparam int unsigned NCH  = (VW + DivStepBits - 1) / DivStepBits;
  localparam int unsigned PW   = NCH * DivStepBits;
  localparam int unsigned CW   = (NCH > 1) ? $clog2(NCH) : 1;

  logic [VW-1:0] val_q, val_d;
  logic          last_q, last_d;
  logic [DW-1:0] div_q, div_d;
  logic [SW-1:0] sq_q, sq_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [PW-1:0] shf_q, shf_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          prime_q, prime_d;

  logic [DW-1:0] rem_next;

  logic [ValueW-1:0] out_value_q, out_value_d;
  logic              out_even_q, out_even_d;
  logic              out_prime_q, out_prime_d;
  logic              out_last_q, out_last_d;

  // Remainder unit: restoring division over one group of dividend bits.
  always_comb begin
    logic [DW:0]   trial;
    logic [DW-1:0] r;
    r = rem_q;
    for (int i = 0; i < DivStepBits; i++) begin
      trial = {r, shf_q[PW-1-i]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      r = trial[DW-1:0];
    end
    rem_next = r;
  end

  // Status toward the controller.
  always_comb begin
    status_o.square_above  = sq_q > SW'(val_q);
    status_o.last_chunk    = cnt_q == CW'(NCH - 1);
    status_o.rem_zero_next = rem_next == '0;
  end

  // Next values of the working registers.
  always_comb begin
    val_d   = val_q;
    last_d  = last_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    shf_d   = shf_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;

    if (cmd_i.load) begin
      val_d  = in_value_i[VW-1:0];
      last_d = in_last_i;
      div_d  = DW'(2);
      sq_d   = SW'(4);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      shf_d = PW'(val_q);
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = rem_next;
      shf_d = shf_q << DivStepBits;
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.next_divisor) begin
      // (d + 1)^2 = d^2 + 2d + 1
      div_d = div_q + DW'(1);
      sq_d  = sq_q + SW'({div_q, 1'b1});
    end
    if (cmd_i.mark_prime) begin
      prime_d = val_q > VW'(1);
    end
    if (cmd_i.mark_composite) begin
      prime_d = 1'b0;
    end
  end

  // Output register contents.
  always_comb begin
    out_value_d = out_value_q;
    out_even_d  = out_even_q;
    out_prime_d = out_prime_q;
    out_last_d  = out_last_q;
    if (cmd_i.out_load) begin
      out_value_d = ValueW'(val_q);
      out_even_d  = ~val_q[0];
      out_prime_d = prime_q;
      out_last_d  = last_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    last_q      <= last_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    shf_q       <= shf_d;
    prime_q     <= prime_d;
    out_value_q <= out_value_d;
    out_even_q  <= out_even_d;
    out_prime_q <= out_prime_d;
    out_last_q  <= out_last_d;
  end

  // The step counter is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign out_value_o = out_value_q;
  assign out_even_o  = out_even_q;
  assign out_prime_o = out_prime_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/ppc_ctrl.sv
// Controller: sequences trial division and owns both stream handshakes.
`timescale 1ns / 1ps
`default_nettype none

module ppc_ctrl
  import ppc_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  input  ppc_status_t  status_i,
  output ppc_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StCheck  = 4'b0010,
    StDiv    = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        // Stop once the divisor squared passes the value.
        if (status_i.square_above) begin
          cmd_o.mark_prime = 1'b1;
          state_d          = StFinish;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last_chunk) begin
          if (status_i.rem_zero_next) begin
            cmd_o.mark_composite = 1'b1;
            state_d              = StFinish;
          end else begin
            cmd_o.next_divisor = 1'b1;
            state_d            = StCheck;
          end
        end
      end
      StFinish: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_d = (out_valid_q & ~out_ready_i) | cmd_o.out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
